// ----- rtl/core/ttam_pkg.sv -----
// ----------------------------------------------------------------------------
// ttam_pkg: shared types and constants for the transpose address map
// Register indexes, reset values, parameter defaults and the control word
// that travels between the index split and index merge pipelines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttam_pkg;

   // parameter defaults
   localparam int DEF_MAX_RANK  = 4;
   localparam int DEF_DIM_BITS  = 16;
   localparam int DEF_POS_BITS  = 24;
   localparam int DEF_ELEM_BITS = 32;

   // axis numbers and effective rank are carried in this many bits (effective rank up to 7)
   localparam int RANK_W      = 4;
   // number of 2-bit destination axis fields held in the axis order register
   localparam int AXIS_FIELDS = 4;

   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RANK = 3'd0,
      REG_DIM0 = 3'd1,
      REG_DIM1 = 3'd2,
      REG_DIM2 = 3'd3,
      REG_DIM3 = 3'd4,
      REG_AXIS = 3'd5
   } csr_reg_type;

   localparam logic [2:0] RANK_RESET = 3'd1;
   localparam logic [7:0] AXIS_RESET = 8'd228;

   typedef struct packed {
      logic valid;
      logic range_err;
   } ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/tensor_transpose_address_map_top.sv -----
// ----------------------------------------------------------------------------
// tensor_transpose_address_map_top: N-d transpose address map
// Maps a row-major source position to its position in the tensor with the
// axes permuted by the configured order; the element value rides along.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   req_     | in  | tdata: src_position, elem_value
//   rsp_     | out | tdata: dst_position, out_value; tuser: range_error
//   csr_     | in  | we / index / wdata, write only
//
// One item per cycle sustained while results are taken. The bit-per-stage
// division chain splits the position into axis indices.
// Synchronous active-high reset empties the pipeline and loads the register
// defaults. A stalled result freezes the whole pipeline; an input skid
// register still takes one item while the result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tensor_transpose_address_map_top import ttam_pkg::*; #(
   parameter int MAX_RANK  = DEF_MAX_RANK,
   parameter int DIM_BITS  = DEF_DIM_BITS,
   parameter int POS_BITS  = DEF_POS_BITS,
   parameter int ELEM_BITS = DEF_ELEM_BITS,
   localparam int DataW    = ((POS_BITS + ELEM_BITS + 7) / 8) * 8,
   localparam int CsrDataW = (DIM_BITS > 8) ? DIM_BITS : 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DataW-1:0]      req_tdata,   // src_position, elem_value
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DataW-1:0]      rsp_tdata,   // dst_position, out_value
   output logic                  rsp_tuser,   // range_error
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CsrDataW-1:0]   csr_wdata
);

   logic                               en;
   logic                               accept;
   logic                               skid_v_ff, skid_v_in;
   logic [POS_BITS-1:0]                skid_pos_ff;
   logic [ELEM_BITS-1:0]               skid_val_ff;
   logic                               skid_load;
   logic                               pipe_valid;
   logic [POS_BITS-1:0]                pipe_pos;
   logic [ELEM_BITS-1:0]               pipe_val;

   logic [RANK_W-1:0]                  eff_rank;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  dim_size;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  divisor;
   logic [7:0]                         axis_order;
   logic                               zero_dim;

   ctl_type                            split_ctl;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  split_idx;
   logic [ELEM_BITS-1:0]               split_val;

   logic                               out_valid;
   logic [POS_BITS-1:0]                out_dst;
   logic [ELEM_BITS-1:0]               out_val;
   logic                               out_err;

   // the pipeline moves as a whole whenever the result register can drain
   assign en         = !out_valid || rsp_tready;
   assign req_tready = !skid_v_ff || en;
   assign accept     = req_tvalid && req_tready;

   assign pipe_valid = skid_v_ff || accept;
   assign pipe_pos   = skid_v_ff ? skid_pos_ff : req_tdata[POS_BITS-1:0];
   assign pipe_val   = skid_v_ff ? skid_val_ff : req_tdata[POS_BITS +: ELEM_BITS];

   // skid holds an item that arrives on a stall, or behind an item it releases
   assign skid_v_in = en ? (skid_v_ff && accept) : (skid_v_ff || accept);
   assign skid_load = accept && (skid_v_ff || !en);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_load) begin
         skid_pos_ff <= req_tdata[POS_BITS-1:0];
         skid_val_ff <= req_tdata[POS_BITS +: ELEM_BITS];
      end
   end

   ttam_csr #(
      .MAX_RANK (MAX_RANK),
      .DIM_BITS (DIM_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .eff_rank   (eff_rank),
      .dim_size   (dim_size),
      .divisor    (divisor),
      .axis_order (axis_order),
      .zero_dim   (zero_dim)
   );

   ttam_split #(
      .MAX_RANK  (MAX_RANK),
      .DIM_BITS  (DIM_BITS),
      .POS_BITS  (POS_BITS),
      .ELEM_BITS (ELEM_BITS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pipe_valid),
      .in_pos    (pipe_pos),
      .in_value  (pipe_val),
      .divisor   (divisor),
      .zero_dim  (zero_dim),
      .out_ctl   (split_ctl),
      .out_idx   (split_idx),
      .out_value (split_val)
   );

   ttam_merge #(
      .MAX_RANK  (MAX_RANK),
      .DIM_BITS  (DIM_BITS),
      .POS_BITS  (POS_BITS),
      .ELEM_BITS (ELEM_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_ctl     (split_ctl),
      .in_idx     (split_idx),
      .in_value   (split_val),
      .eff_rank   (eff_rank),
      .dim_size   (dim_size),
      .axis_order (axis_order),
      .out_valid  (out_valid),
      .out_dst    (out_dst),
      .out_value  (out_val),
      .out_err    (out_err)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = DataW'({out_val, out_dst});
   assign rsp_tuser  = out_err;

endmodule

`default_nettype wire

// ----- rtl/core/ttam_csr.sv -----
// ----------------------------------------------------------------------------
// ttam_csr: configuration registers
// Holds rank, axis extents and axis order; derives effective rank, per-axis
// divisors (extent 1 outside the rank) and the zero-extent flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttam_csr import ttam_pkg::*; #(
   parameter int MAX_RANK = DEF_MAX_RANK,
   parameter int DIM_BITS = DEF_DIM_BITS,
   localparam int CsrDataW = (DIM_BITS > 8) ? DIM_BITS : 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [CSR_IDX_W-1:0]               csr_index,
   input  logic [CsrDataW-1:0]                csr_wdata,
   output logic [RANK_W-1:0]                  eff_rank,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  dim_size,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  divisor,
   output logic [7:0]                         axis_order,
   output logic                               zero_dim
);

   localparam int NumDimRegs = (MAX_RANK < AXIS_FIELDS) ? MAX_RANK : AXIS_FIELDS;

   logic [2:0]                          rank_ff;
   logic [7:0]                          axis_ff;
   logic [NumDimRegs-1:0][DIM_BITS-1:0] dim_ff;
   logic [MAX_RANK-1:0]                 zero_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
         axis_ff <= AXIS_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_RANK) begin
            rank_ff <= csr_wdata[2:0];
         end
         if (csr_index == REG_AXIS) begin
            axis_ff <= csr_wdata[7:0];
         end
      end
   end

   for (genvar i = 0; i < NumDimRegs; i++) begin : g_dim
      logic hit;
      assign hit = csr_we && (csr_index == (CSR_IDX_W'(REG_DIM0) + CSR_IDX_W'(i)));
      always_ff @(posedge clock) begin
         if (reset) begin
            dim_ff[i] <= DIM_BITS'(1);
         end else if (hit) begin
            dim_ff[i] <= csr_wdata[DIM_BITS-1:0];
         end
      end
   end

   // rank 0 acts as 1, anything above MAX_RANK saturates
   always_comb begin
      if (rank_ff == 3'd0) begin
         eff_rank = RANK_W'(1);
      end else if ({1'b0, rank_ff} > RANK_W'(MAX_RANK)) begin
         eff_rank = RANK_W'(MAX_RANK);
      end else begin
         eff_rank = {1'b0, rank_ff};
      end
   end

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_axis
      logic in_use;
      if (i < NumDimRegs) begin : g_reg
         assign dim_size[i] = dim_ff[i];
      end else begin : g_one
         assign dim_size[i] = DIM_BITS'(1);
      end
      assign in_use      = RANK_W'(i) < eff_rank;
      assign divisor[i]  = in_use ? dim_size[i] : DIM_BITS'(1);
      assign zero_hit[i] = in_use && (dim_size[i] == '0);
   end

   assign zero_dim   = |zero_hit;
   assign axis_order = axis_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ttam_split.sv -----
// ----------------------------------------------------------------------------
// ttam_split: position to per-axis index pipeline
// Chained restoring division, one quotient bit per stage, innermost axis
// first. Each axis leaves its remainder as the index and hands the quotient
// on; a nonzero final quotient, or any zero extent, means a range error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttam_split import ttam_pkg::*; #(
   parameter int MAX_RANK  = DEF_MAX_RANK,
   parameter int DIM_BITS  = DEF_DIM_BITS,
   parameter int POS_BITS  = DEF_POS_BITS,
   parameter int ELEM_BITS = DEF_ELEM_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [POS_BITS-1:0]                in_pos,
   input  logic [ELEM_BITS-1:0]               in_value,
   input  logic [MAX_RANK-1:0][DIM_BITS-1:0]  divisor,
   input  logic                               zero_dim,
   output ctl_type                            out_ctl,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  out_idx,
   output logic [ELEM_BITS-1:0]               out_value
);

   localparam int NumSteps = MAX_RANK * POS_BITS;

   logic [NumSteps-1:0]                v_ff, v_in;
   logic [POS_BITS-1:0]                num_ff [NumSteps];
   logic [POS_BITS-1:0]                num_in [NumSteps];
   logic [DIM_BITS-1:0]                rem_ff [NumSteps];
   logic [DIM_BITS-1:0]                rem_in [NumSteps];
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_ff [NumSteps];
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_in [NumSteps];
   logic [ELEM_BITS-1:0]               val_ff [NumSteps];
   logic [ELEM_BITS-1:0]               val_in [NumSteps];

   for (genvar s = 0; s < NumSteps; s++) begin : g_step
      localparam int Axis    = MAX_RANK - 1 - s / POS_BITS;
      localparam bit LastBit = (s % POS_BITS) == (POS_BITS - 1);

      logic                               v_prev;
      logic [POS_BITS-1:0]                num_prev;
      logic [DIM_BITS-1:0]                rem_prev;
      logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_prev;
      logic [ELEM_BITS-1:0]               val_prev;
      logic [DIM_BITS:0]                  trial;
      logic [DIM_BITS:0]                  diff;
      logic                               fits;
      logic [DIM_BITS-1:0]                rem_new;
      logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_new;

      if (s == 0) begin : g_head
         assign v_prev   = in_valid;
         assign num_prev = in_pos;
         assign rem_prev = '0;
         assign idx_prev = '0;
         assign val_prev = in_value;
      end else begin : g_body
         assign v_prev   = v_ff[s-1];
         assign num_prev = num_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign idx_prev = idx_ff[s-1];
         assign val_prev = val_ff[s-1];
      end

      // shift the next dividend bit into the partial remainder
      assign trial   = {rem_prev, num_prev[POS_BITS-1]};
      assign diff    = trial - {1'b0, divisor[Axis]};
      assign fits    = trial >= {1'b0, divisor[Axis]};
      assign rem_new = fits ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];

      always_comb begin
         idx_new = idx_prev;
         if (LastBit) begin
            idx_new[Axis] = rem_new;
         end
      end

      // quotient bits fill the dividend register from the bottom
      assign v_in[s]   = v_prev;
      assign num_in[s] = {num_prev[POS_BITS-2:0], fits};
      assign rem_in[s] = LastBit ? '0 : rem_new;
      assign idx_in[s] = idx_new;
      assign val_in[s] = val_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         idx_ff <= idx_in;
         val_ff <= val_in;
      end
   end

   assign out_ctl.valid     = v_ff[NumSteps-1];
   assign out_ctl.range_err = zero_dim || (num_ff[NumSteps-1] != '0);
   assign out_idx           = idx_ff[NumSteps-1];
   assign out_value         = val_ff[NumSteps-1];

endmodule

`default_nettype wire

// ----- rtl/core/ttam_merge.sv -----
// ----------------------------------------------------------------------------
// ttam_merge: permuted index to destination position pipeline
// One stage per destination axis, innermost first: the index product and
// the running stride product are registered, the sum is folded in one stage
// later. A result register follows the last axis stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttam_merge import ttam_pkg::*; #(
   parameter int MAX_RANK  = DEF_MAX_RANK,
   parameter int DIM_BITS  = DEF_DIM_BITS,
   parameter int POS_BITS  = DEF_POS_BITS,
   parameter int ELEM_BITS = DEF_ELEM_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  ctl_type                            in_ctl,
   input  logic [MAX_RANK-1:0][DIM_BITS-1:0]  in_idx,
   input  logic [ELEM_BITS-1:0]               in_value,
   input  logic [RANK_W-1:0]                  eff_rank,
   input  logic [MAX_RANK-1:0][DIM_BITS-1:0]  dim_size,
   input  logic [7:0]                         axis_order,
   output logic                               out_valid,
   output logic [POS_BITS-1:0]                out_dst,
   output logic [ELEM_BITS-1:0]               out_value,
   output logic                               out_err
);

   localparam int MulW = POS_BITS + DIM_BITS;

   logic [MAX_RANK-1:0]                v_ff, v_in;
   logic [MAX_RANK-1:0]                err_ff, err_in;
   logic [POS_BITS-1:0]                dst_ff  [MAX_RANK];
   logic [POS_BITS-1:0]                dst_in  [MAX_RANK];
   logic [POS_BITS-1:0]                m_ff    [MAX_RANK];
   logic [POS_BITS-1:0]                m_in    [MAX_RANK];
   logic [POS_BITS-1:0]                prod_ff [MAX_RANK];
   logic [POS_BITS-1:0]                prod_in [MAX_RANK];
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_ff  [MAX_RANK];
   logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_in  [MAX_RANK];
   logic [ELEM_BITS-1:0]               val_ff  [MAX_RANK];
   logic [ELEM_BITS-1:0]               val_in  [MAX_RANK];

   logic                  out_valid_ff;
   logic [POS_BITS-1:0]   out_dst_ff, out_dst_in;
   logic [ELEM_BITS-1:0]  out_val_ff;
   logic                  out_err_ff;

   for (genvar t = 0; t < MAX_RANK; t++) begin : g_axis
      localparam int K = MAX_RANK - 1 - t;

      logic                               v_prev;
      logic                               err_prev;
      logic [POS_BITS-1:0]                dst_prev;
      logic [POS_BITS-1:0]                m_prev;
      logic [POS_BITS-1:0]                prod_prev;
      logic [MAX_RANK-1:0][DIM_BITS-1:0]  idx_prev;
      logic [ELEM_BITS-1:0]               val_prev;
      logic [RANK_W-1:0]                  src_axis;
      logic                               active;
      logic                               src_ok;
      logic [DIM_BITS-1:0]                ix;
      logic [DIM_BITS-1:0]                ext;
      logic [MulW-1:0]                    ix_mul;
      logic [MulW-1:0]                    ext_mul;

      if (t == 0) begin : g_head
         assign v_prev    = in_ctl.valid;
         assign err_prev  = in_ctl.range_err;
         assign dst_prev  = '0;
         assign m_prev    = '0;
         assign prod_prev = POS_BITS'(1);
         assign idx_prev  = in_idx;
         assign val_prev  = in_value;
      end else begin : g_body
         assign v_prev    = v_ff[t-1];
         assign err_prev  = err_ff[t-1];
         assign dst_prev  = dst_ff[t-1];
         assign m_prev    = m_ff[t-1];
         assign prod_prev = prod_ff[t-1];
         assign idx_prev  = idx_ff[t-1];
         assign val_prev  = val_ff[t-1];
      end

      // destination axes past the order register keep their own source axis
      if (K < AXIS_FIELDS) begin : g_field
         assign src_axis = RANK_W'(axis_order[2*K +: 2]);
      end else begin : g_ident
         assign src_axis = RANK_W'(K);
      end

      assign active = RANK_W'(K) < eff_rank;
      assign src_ok = src_axis < eff_rank;

      // a source axis outside the rank contributes index 0, extent 1
      always_comb begin
         ix  = '0;
         ext = DIM_BITS'(1);
         if (src_ok) begin
            for (int j = 0; j < MAX_RANK; j++) begin
               if (src_axis == RANK_W'(j)) begin
                  ix  = idx_prev[j];
                  ext = dim_size[j];
               end
            end
         end
      end

      assign ix_mul  = {{POS_BITS{1'b0}}, ix} * {{DIM_BITS{1'b0}}, prod_prev};
      assign ext_mul = {{POS_BITS{1'b0}}, ext} * {{DIM_BITS{1'b0}}, prod_prev};

      assign v_in[t]    = v_prev;
      assign err_in[t]  = err_prev;
      assign dst_in[t]  = dst_prev + m_prev;
      assign m_in[t]    = active ? ix_mul[POS_BITS-1:0] : '0;
      assign prod_in[t] = active ? ext_mul[POS_BITS-1:0] : prod_prev;
      assign idx_in[t]  = idx_prev;
      assign val_in[t]  = val_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_ff  <= err_in;
         dst_ff  <= dst_in;
         m_ff    <= m_in;
         prod_ff <= prod_in;
         idx_ff  <= idx_in;
         val_ff  <= val_in;
      end
   end

   // final sum; an out-of-range item reports position zero
   assign out_dst_in = err_ff[MAX_RANK-1] ? '0 : (dst_ff[MAX_RANK-1] + m_ff[MAX_RANK-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[MAX_RANK-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_dst_ff <= out_dst_in;
         out_val_ff <= val_ff[MAX_RANK-1];
         out_err_ff <= err_ff[MAX_RANK-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_dst   = out_dst_ff;
   assign out_value = out_val_ff;
   assign out_err   = out_err_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ttam_checker.sv -----
// ----------------------------------------------------------------------------
// ttam_checker: port-level checks for the transpose address map
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttam_checker import ttam_pkg::*; #(
   parameter int POS_BITS  = DEF_POS_BITS,
   parameter int ELEM_BITS = DEF_ELEM_BITS,
   localparam int DataW    = ((POS_BITS + ELEM_BITS + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DataW-1:0]  rsp_tdata,
   input logic              rsp_tuser
);

   // a held result stays offered with the same contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item dropped or changed while stalled");

   // an out-of-range item reports destination zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[POS_BITS-1:0] == '0)
      else $error("range error with nonzero destination");

   // the input only backs up while a result is stalled at the output
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

   // an item taken under a stall fills the skid: no second item while the stall lasts
   a_accept_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> !req_tready || rsp_tready)
      else $error("second item taken while stalled");

endmodule

bind tensor_transpose_address_map_top ttam_checker #(
   .POS_BITS  (POS_BITS),
   .ELEM_BITS (ELEM_BITS)
) u_ttam_checker (.*);

`default_nettype wire

// ----- dv/tb_tensor_transpose_address_map_top.sv -----
// ----------------------------------------------------------------------------
// tb_tensor_transpose_address_map_top: transpose address map testbench
// Streams tensor elements through the block under a series of shapes and
// axis orders. Untyped items are mapped by an in-bench model of the
// index split, permute and merge. Every result is compared field by field
// with the oldest outstanding prediction. A short directed table covers
// reset defaults, extents at their limits, rank clamping, zero extents,
// saturated counts and repeated axes. Random phases with random shapes
// follow. Both sides stall in random bursts except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tensor_transpose_address_map_top;
   import ttam_pkg::*;

   localparam int POS_W   = DEF_POS_BITS;
   localparam int VAL_W   = DEF_ELEM_BITS;
   localparam int DIM_W   = DEF_DIM_BITS;
   localparam int DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
   localparam int CSR_W   = (DIM_W > 8) ? DIM_W : 8;
   localparam int LATENCY = DEF_MAX_RANK * DEF_POS_BITS + DEF_MAX_RANK + 1;
   localparam longint unsigned POS_CAP  = 64'd1 << POS_W;
   localparam longint unsigned POS_MASK = POS_CAP - 1;
   localparam logic [POS_W-1:0] MAX_POS = '1;
   localparam logic [CSR_IDX_W-1:0] FIRST_SPARE_REG = 3'd6;
   localparam logic [CSR_IDX_W-1:0] LAST_SPARE_REG  = 3'd7;
   localparam logic [7:0] AXIS_REVERSED = 8'h1B;
   localparam logic [7:0] AXIS_SWAP01   = 8'hE1;
   localparam logic [7:0] AXIS_ALL0     = 8'h00;
   localparam logic [7:0] AXIS_ALL3     = 8'hFF;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int PAUSE_PHASE     = 2;

   typedef struct packed {
      logic [2:0]            rank;
      logic [3:0][DIM_W-1:0] dims;
      logic [7:0]            axis;
   } shape_cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] dst;
      logic [VAL_W-1:0] value;
      logic             err;
   } mapped_elem_type;

   typedef struct packed {
      int unsigned      shape;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] value;
      logic             typed;
      logic [POS_W-1:0] exp_dst;
      logic             exp_err;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;   // src_position, elem_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [DATA_W-1:0]     rsp_tdata;   // dst_position, out_value
   logic                  rsp_tuser;   // range_error
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   mapped_elem_type expected_q[$];
   dir_row_type     directed_rows[$];
   shape_cfg_type   directed_shapes[$];
   shape_cfg_type   live_cfg;
   int unsigned     fail_count = 0;
   bit              idle_on = 1'b1;
   int unsigned     rsp_hold = 0;

   tensor_transpose_address_map_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------- transpose model ----------------

   function automatic int eff_rank(logic [2:0] rv);
      int v;
      v = rv;
      if (v == 0) v = 1;
      if (v > DEF_MAX_RANK) v = DEF_MAX_RANK;
      return v;
   endfunction

   // product saturated at 2^POS_W
   function automatic longint unsigned cap_mul(longint unsigned a, longint unsigned b);
      if (a == 0 || b == 0) return 0;
      if (a > POS_CAP / b) return POS_CAP;
      return (a * b > POS_CAP) ? POS_CAP : a * b;
   endfunction

   function automatic longint unsigned element_count(shape_cfg_type c);
      longint unsigned cnt;
      int r, k;
      r = eff_rank(c.rank);
      cnt = 1;
      for (k = r - 1; k >= 0; k--) cnt = cap_mul(cnt, c.dims[k]);
      return cnt;
   endfunction

   function automatic mapped_elem_type map_element(shape_cfg_type c, logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] value);
      longint unsigned stride [4];
      longint unsigned axis_idx [4];
      longint unsigned cnt, dst, prod, ix, ext;
      int r, k, a;
      mapped_elem_type m;
      r = eff_rank(c.rank);
      cnt = 1;
      for (k = r - 1; k >= 0; k--) begin
         stride[k] = cnt;
         cnt = cap_mul(cnt, c.dims[k]);
      end
      m.value = value;
      m.err   = (pos >= cnt);
      m.dst   = '0;
      if (!m.err) begin
         for (k = 0; k < r; k++) axis_idx[k] = (pos / stride[k]) % c.dims[k];
         dst = 0;
         prod = 1;
         for (k = r - 1; k >= 0; k--) begin
            a = (c.axis >> (2 * k)) & 8'd3;
            // destination axis naming an unused source axis: index 0, extent 1
            if (a < r) begin
               ix  = axis_idx[a];
               ext = c.dims[a];
            end else begin
               ix  = 0;
               ext = 1;
            end
            dst  = (dst + ix * prod) & POS_MASK;
            prod = (prod * ext) & POS_MASK;
         end
         m.dst = dst[POS_W-1:0];
      end
      return m;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic void add_shape(logic [2:0] rank, logic [DIM_W-1:0] d0,
                                     logic [DIM_W-1:0] d1, logic [DIM_W-1:0] d2,
                                     logic [DIM_W-1:0] d3, logic [7:0] axis);
      shape_cfg_type c;
      c.rank = rank;
      c.dims[0] = d0;
      c.dims[1] = d1;
      c.dims[2] = d2;
      c.dims[3] = d3;
      c.axis = axis;
      directed_shapes.push_back(c);
   endfunction

   function automatic void add_row(int unsigned shape, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] value, logic typed,
                                   logic [POS_W-1:0] exp_dst, logic exp_err);
      dir_row_type row;
      row.shape = shape;
      row.pos = pos;
      row.value = value;
      row.typed = typed;
      row.exp_dst = exp_dst;
      row.exp_err = exp_err;
      directed_rows.push_back(row);
   endfunction

   function automatic shape_cfg_type random_shape();
      shape_cfg_type c;
      logic [1:0] perm [4];
      logic [1:0] tmp;
      int unsigned k, j, s;
      int r;
      c.rank = 3'(($urandom_range(0, 15) < 12) ? $urandom_range(1, 4)
                                                 : $urandom_range(0, 7));
      for (k = 0; k < 4; k++) begin
         s = $urandom_range(0, 19);
         if (s < 14)       c.dims[k] = DIM_W'($urandom_range(1, 12));
         else if (s < 18)  c.dims[k] = DIM_W'($urandom_range(1, 65535));
         else if (s == 18) c.dims[k] = '0;
         else              c.dims[k] = '1;
      end
      r = eff_rank(c.rank);
      if ($urandom_range(0, 3) != 0) begin
         for (k = 0; k < 4; k++) perm[k] = 2'(k);
         for (k = r - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
         end
         for (k = 0; k < 4; k++) c.axis[2*k +: 2] = perm[k];
      end else begin
         c.axis = 8'($urandom);
      end
      return c;
   endfunction

   function automatic logic [POS_W-1:0] random_position(shape_cfg_type c);
      longint unsigned cnt;
      int unsigned s, lim;
      logic [POS_W-1:0] p;
      cnt = element_count(c);
      s = $urandom_range(0, 9);
      lim = (cnt == 0) ? 32'd0 : 32'(cnt - 1);
      if (cnt != 0 && s < 7)        p = POS_W'($urandom_range(0, lim));
      else if (s < 8 && cnt < POS_CAP) p = POS_W'(cnt);
      else if (s < 9)               p = POS_W'($urandom);
      else                          p = $urandom_range(0, 1) ? MAX_POS : POS_W'(lim);
      return p;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // registers are only rewritten with the pipeline empty
   task automatic load_shape(shape_cfg_type c);
      logic [CSR_W-1:0] junk;
      req_tvalid <= 1'b0;
      wait_drained();
      junk = CSR_W'($urandom);
      write_reg(REG_RANK, {junk[CSR_W-1:3], c.rank});
      write_reg(REG_DIM0, c.dims[0]);
      write_reg(REG_DIM1, c.dims[1]);
      write_reg(REG_DIM2, c.dims[2]);
      write_reg(REG_DIM3, c.dims[3]);
      junk = CSR_W'($urandom);
      write_reg(REG_AXIS, {junk[CSR_W-1:8], c.axis});
      // unmapped index must leave everything alone
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? LAST_SPARE_REG : FIRST_SPARE_REG,
                   CSR_W'($urandom));
      csr_we <= 1'b0;
      live_cfg = c;
      @(posedge clock);
   endtask

   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_element(logic [POS_W-1:0] pos, logic [VAL_W-1:0] value,
                               mapped_elem_type want);
      req_tvalid <= 1'b1;
      req_tdata  <= {value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(want);
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_hold = 0;
         rsp_tready <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mapped_elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected item: dst=%h value=%h err=%b",
                        rsp_tdata[POS_W-1:0], rsp_tdata[POS_W +: VAL_W], rsp_tuser);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[POS_W-1:0] !== want.dst || rsp_tdata[POS_W +: VAL_W] !== want.value
                || rsp_tuser !== want.err) begin
               if (fail_count < 10)
                  $display("mismatch: exp dst=%h value=%h err=%b, got dst=%h value=%h err=%b",
                           want.dst, want.value, want.err, rsp_tdata[POS_W-1:0],
                           rsp_tdata[POS_W +: VAL_W], rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      int unsigned cur_shape;
      int unsigned phase, n;
      dir_row_type row;
      mapped_elem_type want;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] value;

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= REG_RANK;
      csr_wdata  <= '0;
      live_cfg.rank = RANK_RESET;
      live_cfg.dims = {4{16'd1}};
      live_cfg.axis = AXIS_RESET;

      add_shape(RANK_RESET, 1, 1, 1, 1, AXIS_RESET);        // reset defaults
      add_shape(4, 2, 3, 4, 5, AXIS_REVERSED);
      add_shape(0, 65535, 1, 1, 1, AXIS_RESET);             // rank zero acts as one
      add_shape(7, 4, 4, 0, 4, AXIS_RESET);                 // clamped rank, zero extent
      add_shape(4, 65535, 65535, 65535, 65535, AXIS_ALL3);  // saturated count, repeats
      add_shape(2, 300, 7, 9, 9, AXIS_SWAP01);              // upper axes unused
      add_shape(3, 4000, 100, 60, 1, AXIS_ALL0);            // repeated axis, wraps

      add_row(0, 0,        32'h0000_0000, 1, 0, 0);
      add_row(0, 1,        32'hFFFF_FFFF, 1, 0, 1);
      add_row(0, MAX_POS,  32'hA5A5_A5A5, 1, 0, 1);
      add_row(1, 0,        32'h1234_5678, 1, 0, 0);
      add_row(1, 119,      32'h5A5A_5A5A, 0, 0, 0);
      add_row(1, 120,      32'hFFFF_FFFF, 1, 0, 1);
      add_row(1, 57,       32'h0000_0001, 0, 0, 0);
      add_row(1, 1,        32'h8000_0000, 0, 0, 0);
      add_row(1, 90,       32'hDEAD_BEEF, 0, 0, 0);
      add_row(2, 65534,    32'h0F0F_0F0F, 1, 65534, 0);
      add_row(2, 65535,    32'hF0F0_F0F0, 1, 0, 1);
      add_row(3, 0,        32'h1111_1111, 1, 0, 1);
      add_row(3, 3,        32'h2222_2222, 1, 0, 1);
      add_row(4, MAX_POS,  32'h3333_3333, 0, 0, 0);
      add_row(4, 24'h123456, 32'h4444_4444, 0, 0, 0);
      add_row(4, 0,        32'h5555_5555, 1, 0, 0);
      add_row(5, 2099,     32'h6666_6666, 0, 0, 0);
      add_row(5, 2100,     32'h7777_7777, 1, 0, 1);
      add_row(5, 1234,     32'h8888_8888, 0, 0, 0);
      add_row(6, MAX_POS,  32'h9999_9999, 0, 0, 0);
      add_row(6, 24'hABCDEF, 32'hCAFE_F00D, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_shape = 0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.shape != cur_shape) begin
            load_shape(directed_shapes[row.shape]);
            cur_shape = row.shape;
         end
         sender_gap();
         if (row.typed) begin
            want.dst   = row.exp_dst;
            want.value = row.value;
            want.err   = row.exp_err;
         end else begin
            want = map_element(live_cfg, row.pos, row.value);
         end
         send_element(row.pos, row.value, want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) idle_on = 1'b0;
         load_shape(random_shape());
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // hold the sender until the pipeline has emptied
            if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            sender_gap();
            pos   = random_position(live_cfg);
            value = $urandom;
            send_element(pos, value, map_element(live_cfg, pos, value));
         end
      end

      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      fail_count += expected_q.size();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/ttam_pkg.sv
rtl/core/ttam_csr.sv
rtl/core/ttam_split.sv
rtl/core/ttam_merge.sv
rtl/core/tensor_transpose_address_map_top.sv
rtl/core/ttam_checker.sv
dv/tb_tensor_transpose_address_map_top.sv
